FILE: rtl/ascii_set_command_to_dac_word_top_assert.svh
// assertion macros shared by the rtl modules
`ifndef ASCII_SET_COMMAND_TO_DAC_WORD_TOP_ASSERT_SVH
`define ASCII_SET_COMMAND_TO_DAC_WORD_TOP_ASSERT_SVH

// same-cycle implication
`define ASCDAC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// next-cycle implication
`define ASCDAC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

FILE: rtl/ascdac_pkg.sv
// package: constants, types and helpers of the ascii set-command decoder
package ascdac_pkg;

   localparam int FRACTION_DIGITS = 6;
   localparam int MAX_FIELD_CHARS = 19;

   localparam int SCALE   = 10 ** FRACTION_DIGITS;
   localparam int HALF    = 5 * SCALE;
   localparam int DIVISOR = 10 * SCALE;

   localparam int CODE_W  = 20;
   localparam int SPI_W   = 32;
   localparam int BYTE_W  = 8;
   localparam int INT_W   = 4;
   localparam int INT_MAX = 15;
   localparam int FRAC_W  = $clog2(SCALE);
   localparam int CNT_W   = $clog2(FRACTION_DIGITS + 1);
   localparam int POS_W   = $clog2(MAX_FIELD_CHARS + 1);
   localparam int MAG_W   = $clog2((INT_MAX + 1) * SCALE);
   localparam int NUM_W   = $clog2(DIVISOR);
   localparam int PROD_W  = NUM_W + CODE_W;

   localparam int FIELD_W    = 3;
   localparam int LAST_FIELD = 4;
   localparam int VALUE_FIELD = 2;

   localparam int KW_W    = 3;
   localparam int KW_DONE = 3;
   localparam int KW_FAIL = 4;

   // long division of the scaled product, a few quotient bits per stage
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = CODE_W / DIV_BITS;

   // queue depth, a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CODE_W-1:0] DAC_FULL = {CODE_W{1'b1}};
   localparam logic [7:0]        SPI_CMD  = 8'h01;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SEP   = 8'h5F;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;

   // parsed voltage of one finished command
   typedef struct packed {
      logic              neg;
      logic [INT_W-1:0]  int_part;
      logic [FRAC_W-1:0] frac_value;
      logic [CNT_W-1:0]  frac_count;
   } queue_entry_type;

   typedef struct packed {
      logic              valid;
      logic              sat;
      logic              neg;
      logic [NUM_W-1:0]  rem;
      logic [CODE_W-1:0] low;
      logic [CODE_W-1:0] quo;
   } div_stage_type;

   function automatic logic [BYTE_W-1:0] kw_char(input logic [KW_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      unique case (idx)
         3'd0:    c = CHAR_S;
         3'd1:    c = CHAR_E;
         3'd2:    c = CHAR_T;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] n);
      logic [FRAC_W-1:0] r;
      r = FRAC_W'(1);
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
         if (i < int'(n)) begin
            r = FRAC_W'(r * FRAC_W'(10));
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/ascdac_front.sv
// front end: per-byte command parser, pushes parsed voltages into the queue
module ascdac_front import ascdac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   input  logic                q_full,
   output logic                q_push,
   output queue_entry_type     q_push_entry
);

   logic [FIELD_W-1:0] field_ff, field_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [KW_W-1:0]    kw_ff, kw_in;
   logic               neg_ff, neg_in;
   logic [INT_W-1:0]   int_ff, int_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               past_ff, past_in;

   logic              accept;
   logic              digit;
   logic [3:0]        digit_val;
   logic [7:0]        int_sum;
   logic [BYTE_W-1:0] c;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_rx_byte;
   assign digit     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign digit_val = digit ? c[3:0] : 4'd0;
   assign int_sum   = 8'(int_ff) * 8'd10 + 8'(digit_val);

   assign q_push_entry = '{neg: neg_ff, int_part: int_ff, frac_value: frac_ff,
                           frac_count: cnt_ff};

   always_comb begin
      field_in = field_ff;
      pos_in   = pos_ff;
      kw_in    = kw_ff;
      neg_in   = neg_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      past_in  = past_ff;
      q_push   = 1'b0;
      if (accept) begin
         priority if (c == CHAR_CR) begin
            q_push   = (kw_ff == KW_W'(KW_DONE));
            field_in = '0;
            pos_in   = '0;
            kw_in    = '0;
            neg_in   = 1'b0;
            int_in   = '0;
            frac_in  = '0;
            cnt_in   = '0;
            past_in  = 1'b0;
         end else if (c == CHAR_SEP && field_ff < FIELD_W'(LAST_FIELD)) begin
            field_in = field_ff + FIELD_W'(1);
            pos_in   = '0;
         end else if (pos_ff < POS_W'(MAX_FIELD_CHARS)) begin
            if (field_ff == '0) begin
               if (kw_ff < KW_W'(KW_DONE) && POS_W'(kw_ff) == pos_ff &&
                   c == kw_char(kw_ff)) begin
                  kw_in = kw_ff + KW_W'(1);
               end else begin
                  kw_in = KW_W'(KW_FAIL);
               end
            end else if (field_ff == FIELD_W'(VALUE_FIELD)) begin
               if (!past_ff) begin
                  priority if (c == CHAR_DOT || c == CHAR_COMMA) begin
                     past_in = 1'b1;
                  end else if (c == CHAR_MINUS && pos_ff == '0) begin
                     neg_in = 1'b1;
                  end else if (digit) begin
                     int_in = (int_sum > 8'(INT_MAX)) ? INT_W'(INT_MAX)
                                                      : int_sum[INT_W-1:0];
                  end else begin
                     // other characters before the separator are ignored
                  end
               end else if (cnt_ff < CNT_W'(FRACTION_DIGITS)) begin
                  // non-digits after the separator count as zero digits
                  frac_in = (frac_ff << 3) + (frac_ff << 1) + FRAC_W'(digit_val);
                  cnt_in  = cnt_ff + CNT_W'(1);
               end
            end
            pos_in = pos_ff + POS_W'(1);
         end else begin
            // overlong field, character dropped
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= '0;
         pos_ff   <= '0;
         kw_ff    <= '0;
         neg_ff   <= 1'b0;
         int_ff   <= '0;
         frac_ff  <= '0;
         cnt_ff   <= '0;
         past_ff  <= 1'b0;
      end else begin
         field_ff <= field_in;
         pos_ff   <= pos_in;
         kw_ff    <= kw_in;
         neg_ff   <= neg_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         cnt_ff   <= cnt_in;
         past_ff  <= past_in;
      end
   end

endmodule

FILE: rtl/ascdac_queue.sv
// small queue between the parser and the code pipeline
`include "ascii_set_command_to_dac_word_top_assert.svh"
module ascdac_queue import ascdac_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output queue_entry_type head_entry
);

   queue_entry_type    entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   // pointers wrap by truncation
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASCDAC_ASSERT_IMP(a_no_push_when_full, clock, reset, push, !full)

endmodule

FILE: rtl/ascdac_back.sv
// back end: voltage to dac code pipeline with output register
`include "ascii_set_command_to_dac_word_top_assert.svh"
module ascdac_back import ascdac_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  queue_entry_type    q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CODE_W-1:0]  rsp_dac_code,
   output logic [SPI_W-1:0]   rsp_spi_word
);

   logic              adv;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_neg_ff, s1_neg_in;
   logic [MAG_W-1:0]  s1_int_ff, s1_int_in;
   logic [MAG_W-1:0]  s1_frac_ff, s1_frac_in;

   logic              s2_valid_ff, s2_valid_in;
   logic              s2_neg_ff, s2_neg_in;
   logic              s2_sat_ff, s2_sat_in;
   logic [NUM_W-1:0]  s2_num_ff, s2_num_in;

   logic [MAG_W-1:0]  mag;
   logic [PROD_W-1:0] prod;

   div_stage_type     div_ff [DIV_STAGES+1];
   div_stage_type     div_in [DIV_STAGES+1];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;

   // whole pipeline moves when the output register is free or drained
   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && q_valid;

   // stage 1: scale integer and fraction parts
   always_comb begin
      s1_valid_in = q_valid;
      s1_neg_in   = q_entry.neg;
      s1_int_in   = MAG_W'(q_entry.int_part) * MAG_W'(SCALE);
      s1_frac_in  = MAG_W'(q_entry.frac_value) *
                    MAG_W'(pow10(CNT_W'(FRACTION_DIGITS) - q_entry.frac_count));
   end

   // stage 2: offset by half scale, detect saturation
   always_comb begin
      mag         = s1_int_ff + s1_frac_ff;
      s2_valid_in = s1_valid_ff;
      s2_neg_in   = s1_neg_ff;
      s2_sat_in   = (mag >= MAG_W'(HALF));
      s2_num_in   = s1_neg_ff ? NUM_W'(MAG_W'(HALF) - mag)
                              : NUM_W'(MAG_W'(HALF) + mag);
   end

   // num * (2^20 - 1), then long division by ten times the scale
   always_comb begin
      logic [NUM_W:0] r;
      logic           qbit;
      prod = {s2_num_ff, {CODE_W{1'b0}}} - PROD_W'(s2_num_ff);
      div_in[0].valid = s2_valid_ff;
      div_in[0].sat   = s2_sat_ff;
      div_in[0].neg   = s2_neg_ff;
      div_in[0].rem   = prod[PROD_W-1:CODE_W];
      div_in[0].low   = prod[CODE_W-1:0];
      div_in[0].quo   = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         div_in[k] = div_ff[k-1];
         for (int b = 0; b < DIV_BITS; b++) begin
            r    = {div_in[k].rem, div_in[k].low[CODE_W-1]};
            qbit = (r >= (NUM_W+1)'(DIVISOR));
            if (qbit) begin
               r = r - (NUM_W+1)'(DIVISOR);
            end
            div_in[k].rem = r[NUM_W-1:0];
            div_in[k].low = {div_in[k].low[CODE_W-2:0], 1'b0};
            div_in[k].quo = {div_in[k].quo[CODE_W-2:0], qbit};
         end
      end
   end

   always_comb begin
      rsp_valid_in = div_ff[DIV_STAGES].valid;
      if (div_ff[DIV_STAGES].sat) begin
         rsp_code_in = div_ff[DIV_STAGES].neg ? '0 : DAC_FULL;
      end else begin
         rsp_code_in = div_ff[DIV_STAGES].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_neg_ff   <= s1_neg_in;
         s1_int_ff   <= s1_int_in;
         s1_frac_ff  <= s1_frac_in;
         s2_neg_ff   <= s2_neg_in;
         s2_sat_ff   <= s2_sat_in;
         s2_num_ff   <= s2_num_in;
         rsp_code_ff <= rsp_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dac_code = rsp_code_ff;
   assign rsp_spi_word = {SPI_CMD, rsp_code_ff, 4'b0000};

   `ASCDAC_ASSERT_IMP(a_pop_needs_entry, clock, reset, q_pop, q_valid)
   `ASCDAC_ASSERT_IMP(a_num_in_range, clock, reset, s2_valid_ff && !s2_sat_ff,
      s2_num_ff < NUM_W'(DIVISOR))
   `ASCDAC_ASSERT_IMP(a_rem_in_range, clock, reset,
      div_ff[DIV_STAGES].valid && !div_ff[DIV_STAGES].sat,
      div_ff[DIV_STAGES].rem < NUM_W'(DIVISOR))
   `ASCDAC_ASSERT_NXT(a_result_lands, clock, reset, adv && div_ff[DIV_STAGES].valid,
      rsp_valid_ff)

endmodule

FILE: rtl/ascii_set_command_to_dac_word_top.sv
// top level: ascii set-command decoder producing dac code and spi word
//
// req_valid/req_ready/req_rx_byte carry one received ascii byte per transfer.
// commands are '_'-separated fields ended by carriage return; when the first
// field is exactly SET, the third field is read as a signed decimal voltage.
// rsp_valid/rsp_ready/rsp_dac_code/rsp_spi_word carry one result per such
// command: the 20-bit code and 0x01 followed by the code shifted left four.
// the parser takes one byte per cycle while req_ready is high; every byte is
// parsed in the cycle it is accepted, so throughput is one byte per cycle.
// a finished command goes through a two-entry queue into a code pipeline
// (scaling multiply, offset and clamp, then a long division by ten times
// the fraction scale at four quotient bits per stage); each result passes
// through the stage 1, stage 2, division and output registers.
// while a result waits with rsp_ready low the whole pipeline holds; the
// parser keeps accepting bytes until the queue is full, then req_ready drops.
// reset clears the parse state, queue and pipeline valids; no result is lost
// or duplicated across stalls.
module ascii_set_command_to_dac_word_top import ascdac_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CODE_W-1:0]  rsp_dac_code,
   output logic [SPI_W-1:0]   rsp_spi_word
);

   logic            q_full;
   logic            q_push;
   queue_entry_type q_push_entry;
   logic            q_pop;
   logic            q_valid;
   queue_entry_type q_head;

   ascdac_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_entry (q_push_entry)
   );

   ascdac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   ascdac_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_dac_code (rsp_dac_code),
      .rsp_spi_word (rsp_spi_word)
   );

endmodule
